[sv/i2p_pkg.sv]
package i2p_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CARET = 8'h5E;

  typedef struct packed {
    logic       func;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       run_last;
    logic       overflow_seen;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOP,
    S_BYTE,
    S_SP3,
    S_TERM
  } state_t;

  typedef enum logic [1:0] {
    MODE_END,
    MODE_CLOSE,
    MODE_OP
  } mode_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_CARET:          p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_echo(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_PCT, CH_SPACE});
  endfunction

endpackage

[sv/infix_to_postfix_converter_core.sv]
// Channel  Direction  Ports                          Payload
// -------  ---------  -----------------------------  --------------------------------
// in       input      in_valid, in_stall, in_data    func, char_in
// out      output     out_valid, out_stall, out_data char_out, char_valid, run_last,
//                                                    overflow_seen
//
// Sequencing: operands, spaces, '(' and '^' pushes and any other item on an empty stack
//   finish in idle. Other items read the stack top in idle and pop through S_TOP, S_BYTE
//   and, for ')' and flush, S_SP3 (a pop prefetches the entry below); a flush ends in S_TERM.
// Reset: clears the stack count, overflow flag, sequencer and output valid; memory is not.
// Stalls: a held result freezes every emitting state; a new transfer is taken only in idle and
//   only when the output register is empty or hands its result on at the same edge.
module infix_to_postfix_converter_core
  import i2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Sequencer and stack bookkeeping
  state_t            state_r, state_nxt;
  mode_t             mode_r, in_mode;
  logic [7:0]        char_r;
  logic [7:0]        top_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              flag_r, flag_nxt;

  // Output register
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Datapath controls
  logic              slot_free;
  logic              in_fire;
  logic              emit;
  out_item_t         emit_data;
  logic              latch;
  logic              top_load;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic              can_push;
  logic              top_cond, more;

  // Stack memory port
  logic              ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [7:0]        ram_wr_data, ram_rd_data;

  i2p_ram #(
    .WIDTH (8),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cnt_m1   = count_r - CNT_W'(1);
  assign cnt_m2   = count_r - CNT_W'(2);
  assign can_push = (count_r < CNT_W'(STACK_DEPTH));

  // Classify the incoming character for the pop modes
  always_comb begin
    if (in_data.func) begin
      in_mode = MODE_END;
    end else if (in_data.char_in == CH_RPAR) begin
      in_mode = MODE_CLOSE;
    end else begin
      in_mode = MODE_OP;
    end
  end

  // Pop condition on the entry presented by the memory read port
  function automatic logic pop_cond(input mode_t m, input logic [7:0] c,
                                    input logic [7:0] top);
    logic r;
    case (m)
      MODE_END:   r = 1'b1;
      MODE_CLOSE: r = (top != CH_LPAR);
      MODE_OP:    r = (prec_of(c) <= prec_of(top));
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

  assign top_cond = pop_cond(mode_r, char_r, ram_rd_data);
  // Valid once a pop has advanced the read to the next entry (or the stack is empty)
  assign more     = (count_r != '0) && top_cond;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && !is_echo(in_data.char_in) && (count_r != '0)) begin
          if (in_data.func || (in_data.char_in != CH_LPAR && in_data.char_in != CH_CARET)) begin
            state_nxt = S_TOP;
          end
        end else if (in_fire && in_data.func) begin
          state_nxt = S_TOP;
        end
        if (in_fire && in_data.func && (count_r == '0)) begin
          state_nxt = S_IDLE;
        end
      end
      S_TOP: begin
        if (!top_cond) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          state_nxt = S_BYTE;
        end
      end
      S_BYTE: begin
        if (slot_free) begin
          if (mode_r == MODE_OP) begin
            state_nxt = more ? S_TOP : S_IDLE;
          end else begin
            state_nxt = S_SP3;
          end
        end
      end
      S_SP3: begin
        if (slot_free) begin
          if (mode_r == MODE_END) begin
            state_nxt = (count_r != '0) ? S_TOP : S_TERM;
          end else begin
            state_nxt = more ? S_TOP : S_IDLE;
          end
        end
      end
      S_TERM: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    emit        = 1'b0;
    emit_data   = '{char_out: CH_SPACE, char_valid: 1'b1, run_last: 1'b0,
                    overflow_seen: flag_r};
    latch       = 1'b0;
    top_load    = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = cnt_m1[ADDR_W-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_r[ADDR_W-1:0];
    ram_wr_data = char_r;
    count_nxt   = count_r;
    flag_nxt    = flag_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          latch       = 1'b1;
          ram_wr_data = in_data.char_in;
          if (in_data.func) begin
            if (count_r != '0) begin
              ram_rd_en = 1'b1;
            end else begin
              // empty stack: terminator right away, then drop the flag
              emit               = 1'b1;
              emit_data.char_out = CH_NUL;
              emit_data.char_valid = 1'b0;
              emit_data.run_last = 1'b1;
              flag_nxt           = 1'b0;
            end
          end else if (is_echo(in_data.char_in)) begin
            emit               = 1'b1;
            emit_data.char_out = in_data.char_in;
            emit_data.run_last = 1'b1;
          end else if (in_data.char_in == CH_LPAR || in_data.char_in == CH_CARET) begin
            if (can_push) begin
              ram_wr_en = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end else begin
              flag_nxt = 1'b1;
            end
          end else if (count_r != '0) begin
            ram_rd_en = 1'b1;
          end else if (in_data.char_in != CH_RPAR) begin
            // operator on an empty stack: push at the bottom
            ram_wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      S_TOP: begin
        if (top_cond) begin
          if (slot_free) begin
            emit      = 1'b1;
            top_load  = 1'b1;
            count_nxt = cnt_m1;
            // prefetch the entry below for the next decision
            if (count_r > CNT_W'(1)) begin
              ram_rd_en   = 1'b1;
              ram_rd_addr = cnt_m2[ADDR_W-1:0];
            end
          end
        end else if (mode_r == MODE_CLOSE) begin
          count_nxt = cnt_m1;
        end else if (mode_r == MODE_OP) begin
          if (can_push) begin
            ram_wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            flag_nxt = 1'b1;
          end
        end
      end
      S_BYTE: begin
        if (slot_free) begin
          emit               = 1'b1;
          emit_data.char_out = top_r;
          emit_data.run_last = (mode_r == MODE_OP) && !more;
          if ((mode_r == MODE_OP) && !more) begin
            ram_wr_en = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      S_SP3: begin
        if (slot_free) begin
          emit               = 1'b1;
          emit_data.run_last = (mode_r == MODE_CLOSE) && !more;
          if ((mode_r == MODE_CLOSE) && !more && (count_r != '0)) begin
            // drop the matching '('
            count_nxt = cnt_m1;
          end
        end
      end
      S_TERM: begin
        if (slot_free) begin
          emit                 = 1'b1;
          emit_data.char_out   = CH_NUL;
          emit_data.char_valid = 1'b0;
          emit_data.run_last   = 1'b1;
          flag_nxt             = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_OP;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flag_r  <= flag_nxt;
      if (latch) begin
        mode_r <= in_mode;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      char_r <= in_data.char_in;
    end
    if (top_load) begin
      top_r <= ram_rd_data;
    end
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd_en |-> (count_r != '0))
    else $error("stack read on empty stack");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> can_push)
    else $error("stack write on full stack");

  a_term_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.char_valid) |->
      (out_data_r.run_last && out_data_r.char_out == CH_NUL))
    else $error("malformed terminator");

  a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TERM && slot_free) |=> !flag_r)
    else $error("overflow flag not cleared after end item");
`endif

endmodule

[sv/i2p_ram.sv]
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import i2p_pkg::*;

  // How a stimulus row is checked: against the shunting-yard predictor, or against a
  // value typed into the table (no result at all, or exactly one result).
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } check_kind_t;

  typedef struct packed {
    in_item_t    item;
    check_kind_t kind;
    out_item_t   res;
  } stim_row_t;

  localparam int RANDOM_ITEMS  = 420;
  localparam int DIRECTED_ROWS = 26;
  localparam int MAX_RESULTS   = 3 * STACK_DEPTH + 1;
  localparam int MAX_GAP       = 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 2 * MAX_RESULTS + 20;
  localparam int MAX_PRINTS    = 25;

  // Worst case: every transfer flushing a full stack, every result stalled for the
  // longest gap, every transfer preceded by the longest gap; then take it three times.
  localparam int CYCLE_LIMIT =
    3 * ((DIRECTED_ROWS + RANDOM_ITEMS + 64) * (MAX_RESULTS * (MAX_GAP + 2) + MAX_GAP + 4)
         + 2 * HOLD_CYCLES) + 10000;

  localparam out_item_t NO_RES     = '0;
  localparam out_item_t TERMINATOR = '{CH_NUL, 1'b0, 1'b1, 1'b0};

  // Directed rows: operands of every class, every operator, parentheses, zero-precedence
  // bytes, an unmatched close on an empty stack and flushes with and without content.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{1'b1, CH_NUL},   CHK_ONE,   TERMINATOR},                   // flush of empty stack
    '{'{1'b0, "a"},      CHK_ONE,   '{"a", 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, "z"},      CHK_ONE,   '{"z", 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, "A"},      CHK_ONE,   '{"A", 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, "0"},      CHK_ONE,   '{"0", 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, CH_PCT},   CHK_ONE,   '{CH_PCT, 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, CH_SPACE}, CHK_ONE,   '{CH_SPACE, 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, CH_LPAR},  CHK_NONE,  NO_RES},                       // push only
    '{'{1'b0, "b"},      CHK_ONE,   '{"b", 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, CH_PLUS},  CHK_MODEL, NO_RES},
    '{'{1'b0, "c"},      CHK_ONE,   '{"c", 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, CH_STAR},  CHK_MODEL, NO_RES},
    '{'{1'b0, "d"},      CHK_ONE,   '{"d", 1'b1, 1'b1, 1'b0}},
    '{'{1'b0, CH_RPAR},  CHK_MODEL, NO_RES},                       // pops * and + to (
    '{'{1'b0, CH_CARET}, CHK_NONE,  NO_RES},
    '{'{1'b0, CH_CARET}, CHK_NONE,  NO_RES},
    '{'{1'b0, CH_MINUS}, CHK_MODEL, NO_RES},                       // pops both carets
    '{'{1'b0, CH_SLASH}, CHK_MODEL, NO_RES},
    '{'{1'b0, 8'h23},    CHK_MODEL, NO_RES},                       // zero rank pops all
    '{'{1'b0, 8'hFF},    CHK_MODEL, NO_RES},
    '{'{1'b0, 8'h80},    CHK_MODEL, NO_RES},
    '{'{1'b0, CH_RPAR},  CHK_MODEL, NO_RES},
    '{'{1'b0, CH_RPAR},  CHK_MODEL, NO_RES},                       // close on empty stack
    '{'{1'b0, CH_NUL},   CHK_MODEL, NO_RES},
    '{'{1'b1, 8'hFF},    CHK_MODEL, NO_RES},                       // flush, byte ignored
    '{'{1'b1, CH_NUL},   CHK_ONE,   TERMINATOR}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  // Check kind and typed result travel with the payload, so the monitor sees the
  // ones that belong to the transfer it is taking.
  check_kind_t pin_kind;
  out_item_t   pin_res;

  // Predictor state: operator stack, its depth and the sticky overflow flag.
  logic [7:0]  ops [STACK_DEPTH];
  int          op_depth = 0;
  logic        ovf_flag = 1'b0;

  out_item_t   burst_q[$];
  out_item_t   postfix_q[$];
  out_item_t   want_r;

  int          items_sent      = 0;
  int          results_checked = 0;
  int          ovf_results     = 0;
  int          deepest         = 0;
  int          err_count       = 0;
  bit          calm_tx         = 1'b0;
  bit          hold_req        = 1'b0;

  infix_to_postfix_converter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shunting-yard predictor
  // ---------------------------------------------------------------------------

  function automatic logic [1:0] op_rank(input logic [7:0] c);
    if (c == CH_CARET) return 2'd3;
    if (c == CH_STAR || c == CH_SLASH) return 2'd2;
    if (c == CH_PLUS || c == CH_MINUS) return 2'd1;
    return 2'd0;
  endfunction

  // Spaces, ASCII letters, digits and percent pass straight through.
  function automatic bit is_echo_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
           c == CH_PCT || c == CH_SPACE;
  endfunction

  function automatic void emit(input logic [7:0] ch, input logic valid);
    out_item_t r;
    r = '0;
    r.char_out   = ch;
    r.char_valid = valid;
    burst_q.insert(burst_q.size(), r);
  endfunction

  // Emit space, top byte and optionally a trailing space, then drop the top.
  function automatic void pop_emit(input bit trail_space);
    emit(CH_SPACE, 1'b1);
    emit(ops[op_depth - 1], 1'b1);
    if (trail_space) emit(CH_SPACE, 1'b1);
    op_depth--;
  endfunction

  // A push onto a full stack is lost and raises the sticky flag.
  function automatic void push_op(input logic [7:0] c);
    if (op_depth >= STACK_DEPTH) begin
      ovf_flag = 1'b1;
    end else begin
      ops[op_depth] = c;
      op_depth++;
      if (op_depth > deepest) deepest = op_depth;
    end
  endfunction

  // Work out the postfix results of one input transfer into burst_q.
  function automatic void convert_item(input in_item_t it);
    logic [7:0] c;
    logic [1:0] p;
    bit         clear_after;
    c           = it.char_in;
    clear_after = 1'b0;
    burst_q.delete();
    if (it.func) begin
      while (op_depth > 0) pop_emit(1'b1);
      emit(CH_NUL, 1'b0);
      clear_after = 1'b1;
    end else if (is_echo_byte(c)) begin
      emit(c, 1'b1);
    end else if (c == CH_LPAR || c == CH_CARET) begin
      push_op(c);
    end else if (c == CH_RPAR) begin
      // Unmatched close stops at the empty stack.
      while (op_depth > 0 && ops[op_depth - 1] != CH_LPAR) pop_emit(1'b1);
      if (op_depth > 0) op_depth--;
    end else begin
      p = op_rank(c);
      while (op_depth > 0 && p <= op_rank(ops[op_depth - 1])) pop_emit(1'b0);
      push_op(c);
    end
    foreach (burst_q[k]) begin
      burst_q[k].run_last      = (k == burst_q.size() - 1);
      burst_q[k].overflow_seen = ovf_flag;
    end
    if (clear_after) ovf_flag = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on each input transfer, check each output transfer.
  // Both sides sit in one block so queue pushes and pops keep a fixed order.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at result %0d: %s got 'h%0h want 'h%0h",
               results_checked, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      convert_item(in_data);
      // Typed rows replace the predicted results; the predictor state still advances.
      if (pin_kind != CHK_MODEL) begin
        burst_q.delete();
        if (pin_kind == CHK_ONE) burst_q.insert(burst_q.size(), pin_res);
      end
      foreach (burst_q[k]) postfix_q.insert(postfix_q.size(), burst_q[k]);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (postfix_q.size() == 0) begin
        report_mismatch("result with nothing expected", int'(out_data), 0);
      end else begin
        want_r = postfix_q.pop_front();
        if (out_data.char_out !== want_r.char_out)
          report_mismatch("char_out", out_data.char_out, want_r.char_out);
        if (out_data.char_valid !== want_r.char_valid)
          report_mismatch("char_valid", out_data.char_valid, want_r.char_valid);
        if (out_data.run_last !== want_r.run_last)
          report_mismatch("run_last", out_data.run_last, want_r.run_last);
        if (out_data.overflow_seen !== want_r.overflow_seen)
          report_mismatch("overflow_seen", out_data.overflow_seen, want_r.overflow_seen);
      end
      if (out_data.overflow_seen === 1'b1) ovf_results++;
      results_checked++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, MAX_GAP);
  endfunction

  function automatic logic [7:0] pick_operand();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r < 62) return 8'h30 + 8'(r - 52);
    return CH_PCT;
  endfunction

  function automatic logic [7:0] pick_oper();
    case ($urandom_range(0, 4))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      default: return CH_CARET;
    endcase
  endfunction

  // Offer one transfer after an optional gap and hold it until taken. Valid stays
  // high on return so a back-to-back transfer needs no second assignment.
  task automatic drive_item(input in_item_t it, input check_kind_t kind,
                            input out_item_t res);
    int gap;
    gap = calm_tx ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    pin_kind <= kind;
    pin_res  <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t it;
    it.func    = 1'b0;
    it.char_in = c;
    drive_item(it, CHK_MODEL, NO_RES);
  endtask

  // Flush with a random don't-care byte alongside.
  task automatic send_end();
    in_item_t it;
    it.func    = 1'b1;
    it.char_in = 8'($urandom_range(0, 255));
    drive_item(it, CHK_MODEL, NO_RES);
  endtask

  // Well-formed expression with random operands, operators and nesting; now and
  // then the closes or the flush are left out to break the sequence.
  task automatic send_expr();
    int depth;
    int terms;
    int t;
    depth = 0;
    terms = $urandom_range(1, 8);
    for (t = 0; t < terms; t++) begin
      while (depth < 6 && $urandom_range(0, 3) == 0) begin
        send_char(CH_LPAR);
        depth++;
      end
      send_char(pick_operand());
      if ($urandom_range(0, 5) == 0) send_char(CH_SPACE);
      while (depth > 0 && $urandom_range(0, 2) == 0) begin
        send_char(CH_RPAR);
        depth--;
      end
      if (t < terms - 1) send_char(pick_oper());
    end
    while (depth > 0 && $urandom_range(0, 7) != 0) begin
      send_char(CH_RPAR);
      depth--;
    end
    if ($urandom_range(0, 9) != 0) send_end();
  endtask

  // Pile up opens and carets until the stack is near or past full, then unwind.
  task automatic send_deep();
    int n;
    int j;
    n = $urandom_range(10, 20);
    for (j = 0; j < n; j++) begin
      case ($urandom_range(0, 3))
        0:       send_char(CH_LPAR);
        1:       send_char(CH_CARET);
        default: begin
          send_char(pick_operand());
          send_char(CH_CARET);
        end
      endcase
    end
    if ($urandom_range(0, 1) == 1) send_char(pick_oper());
    send_char(pick_operand());
    for (j = $urandom_range(0, n); j > 0; j--) send_char(CH_RPAR);
    send_end();
  endtask

  // Raw bytes across the whole range, stray flushes among them.
  task automatic send_noise();
    int n;
    in_item_t it;
    n = $urandom_range(1, 6);
    repeat (n) begin
      it.func    = ($urandom_range(0, 7) == 0);
      it.char_in = 8'($urandom_range(0, 255));
      drive_item(it, CHK_MODEL, NO_RES);
    end
    if ($urandom_range(0, 1) == 1) send_end();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, calm stretches, and a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int stall_len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // Hold off long enough for the block to fill and stall its input.
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 15) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  initial begin
    int cyc;
    for (cyc = 0; cyc < CYCLE_LIMIT; cyc++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still expected", cyc, postfix_q.size());
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random expressions, drain
  // ---------------------------------------------------------------------------

  initial begin
    int  i;
    int  hold_cnt;
    bit  drained_once;
    hold_cnt     = 0;
    drained_once = 1'b0;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    pin_kind <= CHK_MODEL;
    pin_res  <= NO_RES;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++)
      drive_item(DIRECTED[i].item, DIRECTED[i].kind, DIRECTED[i].res);

    while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      calm_tx = ($urandom_range(0, 5) == 0);
      if (hold_cnt < 2 && items_sent >= 120 + 200 * hold_cnt) begin
        // Keep offering back-to-back transfers while the receiver holds off.
        hold_req = 1'b1;
        hold_cnt++;
        calm_tx  = 1'b1;
        send_deep();
      end else if (!drained_once && items_sent >= 230) begin
        // Drop valid and wait for every pending result before going on.
        in_valid <= 1'b0;
        @(posedge clk);
        while (postfix_q.size() != 0) @(posedge clk);
        drained_once = 1'b1;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_expr();
          6, 7:             send_deep();
          default:          send_noise();
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
    // Catch any extra result the block might still emit.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d input transfers, %0d postfix results checked, %0d mismatches",
             items_sent, results_checked, err_count);
    $display("run: deepest operator stack %0d of %0d, %0d results carried the overflow flag",
             deepest, STACK_DEPTH, ovf_results);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/i2p_pkg.sv
sv/i2p_ram.sv
sv/infix_to_postfix_converter_core.sv
tb/sv/testbench.sv
